// ===== rtl/fdpm_pkg.sv =====
// Types and constants shared by the fall detection phase machine.
`timescale 1ns / 1ps
`default_nettype none
package fdpm_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned MagW  = 16;
  localparam int unsigned RegW  = 16;
  localparam int unsigned IdxW  = 3;

  // Q4.12 representation of 1 g
  localparam logic [MagW-1:0]  ONE_G_Q12        = 16'd4096;
  localparam logic [TimeW-1:0] COOLDOWN_MS      = 32'd10000;
  localparam logic [TimeW-1:0] FREE_FALL_MAX_MS = 32'd1000;
  localparam logic [15:0]      FALL_TOTAL_MAX   = 16'hFFFF;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_FREE_FALL_LEVEL    = 3'd0;
  localparam logic [IdxW-1:0] REG_FREE_FALL_MIN_TIME = 3'd1;
  localparam logic [IdxW-1:0] REG_IMPACT_LEVEL       = 3'd2;
  localparam logic [IdxW-1:0] REG_IMPACT_WAIT_LIMIT  = 3'd3;
  localparam logic [IdxW-1:0] REG_STILL_WAIT_LIMIT   = 3'd4;
  localparam logic [IdxW-1:0] REG_STILL_ACCEL_BAND   = 3'd5;
  localparam logic [IdxW-1:0] REG_STILL_GYRO_LEVEL   = 3'd6;
  localparam logic [IdxW-1:0] REG_STILL_HOLD_TIME    = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FREE   = 3'd1,
    PH_IMPACT = 3'd2,
    PH_STILL  = 3'd3,
    PH_COOL   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic [MagW-1:0]  raw_accel_mag;
    logic [MagW-1:0]  filtered_accel_mag;
    logic [MagW-1:0]  filtered_gyro_mag;
  } sample_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        fall_detected;
    logic [15:0] falls_so_far;
  } result_t;

  typedef struct packed {
    logic [RegW-1:0] free_fall_level;
    logic [RegW-1:0] free_fall_min_time;
    logic [RegW-1:0] impact_level;
    logic [RegW-1:0] impact_wait_limit;
    logic [RegW-1:0] still_wait_limit;
    logic [RegW-1:0] still_accel_band;
    logic [RegW-1:0] still_gyro_level;
    logic [RegW-1:0] still_hold_time;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/fdpm_cfg.sv =====
// Configuration register file for the fall detection phase machine.
`timescale 1ns / 1ps
`default_nettype none
module fdpm_cfg
  import fdpm_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [IdxW-1:0] cfg_index,
  input  wire logic [RegW-1:0] cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.free_fall_level    <= 16'd2048;
      cfg.free_fall_min_time <= 16'd100;
      cfg.impact_level       <= 16'd10240;
      cfg.impact_wait_limit  <= 16'd1000;
      cfg.still_wait_limit   <= 16'd5000;
      cfg.still_accel_band   <= 16'd819;
      cfg.still_gyro_level   <= 16'd320;
      cfg.still_hold_time    <= 16'd2000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FREE_FALL_LEVEL:    cfg.free_fall_level    <= cfg_data;
        REG_FREE_FALL_MIN_TIME: cfg.free_fall_min_time <= cfg_data;
        REG_IMPACT_LEVEL:       cfg.impact_level       <= cfg_data;
        REG_IMPACT_WAIT_LIMIT:  cfg.impact_wait_limit  <= cfg_data;
        REG_STILL_WAIT_LIMIT:   cfg.still_wait_limit   <= cfg_data;
        REG_STILL_ACCEL_BAND:   cfg.still_accel_band   <= cfg_data;
        REG_STILL_GYRO_LEVEL:   cfg.still_gyro_level   <= cfg_data;
        REG_STILL_HOLD_TIME:    cfg.still_hold_time    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fdpm_core.sv =====
// Phase state machine, timestamps, fall counter and result register.
`timescale 1ns / 1ps
`default_nettype none
module fdpm_core
  import fdpm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    step,
  input  wire sample_t sample,
  input  wire logic    result_ready,
  output logic         result_valid,
  output result_t      result
);

  phase_t            phase, phase_next;
  logic [TimeW-1:0]  phase_begin, phase_begin_next;
  logic [TimeW-1:0]  still_begin, still_begin_next;
  logic [TimeW-1:0]  fall_begin, fall_begin_next;
  logic [TimeW-1:0]  cool_begin, cool_begin_next;
  logic [15:0]       fall_total, fall_total_next;
  logic              confirmed;

  logic [TimeW-1:0]  now;
  logic [TimeW-1:0]  fall_el, phase_el, still_el, cool_el;
  logic [MagW-1:0]   dev;
  logic              is_still;

  assign now      = sample.time_ms;
  assign fall_el  = now - fall_begin;
  assign phase_el = now - phase_begin;
  assign still_el = now - still_begin;
  assign cool_el  = now - cool_begin;
  assign dev      = (sample.filtered_accel_mag >= ONE_G_Q12)
                  ? (sample.filtered_accel_mag - ONE_G_Q12)
                  : (ONE_G_Q12 - sample.filtered_accel_mag);
  assign is_still = (dev < cfg.still_accel_band) &&
                    (sample.filtered_gyro_mag < cfg.still_gyro_level);

  always_comb begin
    phase_next       = phase;
    phase_begin_next = phase_begin;
    still_begin_next = still_begin;
    fall_begin_next  = fall_begin;
    cool_begin_next  = cool_begin;
    fall_total_next  = fall_total;
    confirmed        = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (sample.raw_accel_mag < cfg.free_fall_level) begin
          phase_next      = PH_FREE;
          fall_begin_next = now;
        end
      end
      PH_FREE: begin
        if (sample.raw_accel_mag >= cfg.free_fall_level) begin
          if (fall_el < {16'd0, cfg.free_fall_min_time}) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next       = PH_IMPACT;
            phase_begin_next = now;
          end
        end else if (fall_el > FREE_FALL_MAX_MS) begin
          phase_next = PH_IDLE;
        end
      end
      PH_IMPACT: begin
        // timeout takes priority over the impact test
        if (phase_el > {16'd0, cfg.impact_wait_limit}) begin
          phase_next = PH_IDLE;
        end else if (sample.raw_accel_mag > cfg.impact_level) begin
          phase_next       = PH_STILL;
          phase_begin_next = now;
          still_begin_next = now;
        end
      end
      PH_STILL: begin
        if (phase_el > {16'd0, cfg.still_wait_limit}) begin
          phase_next = PH_IDLE;
        end else if (is_still) begin
          if (still_el >= {16'd0, cfg.still_hold_time}) begin
            if (fall_total != FALL_TOTAL_MAX) begin
              fall_total_next = fall_total + 16'd1;
            end
            confirmed       = 1'b1;
            phase_next      = PH_COOL;
            cool_begin_next = now;
          end
        end else begin
          // restart the hold on any movement
          still_begin_next = now;
        end
      end
      PH_COOL: begin
        if (cool_el >= COOLDOWN_MS) begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_begin <= '0;
      still_begin <= '0;
      fall_begin  <= '0;
      cool_begin  <= '0;
      fall_total  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      phase_begin <= phase_begin_next;
      still_begin <= still_begin_next;
      fall_begin  <= fall_begin_next;
      cool_begin  <= cool_begin_next;
      fall_total  <= fall_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.phase         <= phase_next;
      result.fall_detected <= confirmed;
      result.falls_so_far  <= fall_total_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fall_detect_phase_machine.sv =====
// Fall detection phase machine: top level with sample register and result stage.
//
// Usage:
//   Samples enter on the sample channel (sample_valid / sample_ready, payload
//   sample) and one result per sample leaves on the result channel
//   (result_valid / result_ready, payload result). Registers are written
//   through cfg_wr_en, cfg_index and cfg_data, one per cycle; the user must
//   write them only while no sample is in flight; the block does not enforce it.
//   Path: a transferred sample waits in the sample register, and the phase
//   logic steps on it once the result stage is free or draining, loading the
//   result register and raising result_valid.
//   Throughput: one sample per cycle while result_ready is high; the single
//   phase state register is updated once per sample.
//   Stall: while result_ready is low the result holds and one more sample may
//   be transferred into the sample register; sample_ready then drops until
//   the result is taken.
//   Reset: rst clears both stages, returns the machine to idle with all
//   timestamps and the fall count at zero, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module fall_detect_phase_machine
  import fdpm_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            sample_valid,
  output logic                 sample_ready,
  input  wire sample_t         sample,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output result_t              result,
  input  wire logic            cfg_wr_en,
  input  wire logic [IdxW-1:0] cfg_index,
  input  wire logic [RegW-1:0] cfg_data
);

  cfg_t    cfg;
  sample_t held;
  logic    held_valid;
  logic    step;

  // advance the held sample whenever the result stage is free or draining
  assign step         = held_valid && (!result_valid || result_ready);
  assign sample_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_ready) begin
      held_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      held <= sample;
    end
  end

  fdpm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fdpm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .step         (step),
    .sample       (held),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire
